### design/t0ax_pkg.sv
// Shared types and constants for the T=0 APDU exchange controller.
// Used by t0_apdu_exchange_control_core; depends on nothing else.
package t0ax_pkg;

  // Result action codes
  localparam logic [1:0] ACT_SEND   = 2'd0;
  localparam logic [1:0] ACT_DONE   = 2'd1;
  localparam logic [1:0] ACT_REJECT = 2'd2;

  // APDU case codes
  localparam logic [2:0] CASE_1    = 3'd0;
  localparam logic [2:0] CASE_2S   = 3'd1;
  localparam logic [2:0] CASE_2E   = 3'd2;
  localparam logic [2:0] CASE_3S   = 3'd3;
  localparam logic [2:0] CASE_3E   = 3'd4;
  localparam logic [2:0] CASE_4S   = 3'd5;
  localparam logic [2:0] CASE_4E   = 3'd6;
  localparam logic [2:0] CASE_IDLE = 3'd7;

  // Request types
  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_STATUS  = 1'b1;

  // Instruction and status bytes
  localparam logic [7:0] INS_GET_RESPONSE = 8'hC0;
  localparam logic [7:0] SW1_WRONG_LE     = 8'h6C;
  localparam logic [7:0] SW1_BYTES_AVAIL  = 8'h61;
  localparam logic [7:0] SW1_SIM_AVAIL    = 8'h9F;
  localparam logic [7:0] SW1_NORMAL       = 8'h90;
  localparam logic [7:0] SW1_NORMAL_LAST  = 8'h9F;

  // Largest Le that fits a short P3
  localparam logic [16:0] LE_SHORT_MAX = 17'd256;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;
  localparam logic [7:0]  COUNT_SECOND = 8'd2;

  // One result item
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  tpdu_class;
    logic [7:0]  tpdu_instruction;
    logic [7:0]  tpdu_param1;
    logic [7:0]  tpdu_param2;
    logic [7:0]  tpdu_param3;
    logic        append_long_le;
    logic [15:0] long_le_value;
    logic        keep_data;
    logic [15:0] final_status;
  } result_t;

endpackage

### design/t0_apdu_exchange_control_core.sv
// T=0 APDU exchange controller: command header mapping and status word decisions.
// Depends on t0ax_pkg.

// Each request (a new command header or a status word from the card) gives
// exactly one result in the output register in the cycle after it is accepted. The
// decision is made by combinational logic between the request port and one output
// register, so a request is taken every cycle, and also while a result waits in
// the output register provided it is being taken in the same cycle. Throughput is
// one request per cycle while the result channel is not stalled. Commands with an
// unused case code or case 3E/4E with Lc of 256 or more are answered with a
// reject, after which status words simply finish.
module t0_apdu_exchange_control_core (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_cmd_class,
  input  logic [7:0]  in_cmd_instruction,
  input  logic [7:0]  in_cmd_param1,
  input  logic [7:0]  in_cmd_param2,
  input  logic [2:0]  in_apdu_case,
  input  logic [15:0] in_command_length,
  input  logic [16:0] in_expected_length,
  input  logic [15:0] in_status_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [7:0]  out_tpdu_class,
  output logic [7:0]  out_tpdu_instruction,
  output logic [7:0]  out_tpdu_param1,
  output logic [7:0]  out_tpdu_param2,
  output logic [7:0]  out_tpdu_param3,
  output logic        out_append_long_le,
  output logic [15:0] out_long_le_value,
  output logic        out_keep_data,
  output logic [15:0] out_final_status
);

  // Exchange state
  logic [2:0]  case_r,  case_nxt;
  logic [16:0] le_r,    le_nxt;
  logic [7:0]  cla_r,   cla_nxt;
  logic [7:0]  ins_r,   ins_nxt;
  logic [7:0]  p1_r,    p1_nxt;
  logic [7:0]  p2_r,    p2_nxt;
  logic [7:0]  p3_r,    p3_nxt;
  logic [7:0]  count_r, count_nxt;

  // Output register
  logic                 out_valid_r;
  t0ax_pkg::result_t    res_r, res_nxt;

  logic accept;
  logic [7:0] sw1, sw2;
  logic [7:0] p3_min;
  logic       reject;
  logic       append;
  logic       resend;
  logic       get_resp;
  logic       keep;
  logic [7:0] new_p3;

  // Take a request when the output register is free or being emptied
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign sw1    = in_status_word[15:8];
  assign sw2    = in_status_word[7:0];
  assign p3_min = (le_r < {9'd0, sw2}) ? le_r[7:0] : sw2;

  // Next state and result
  always_comb begin
    case_nxt  = case_r;
    le_nxt    = le_r;
    cla_nxt   = cla_r;
    ins_nxt   = ins_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    p3_nxt    = p3_r;
    count_nxt = count_r;
    res_nxt   = '0;
    reject    = 1'b0;
    append    = 1'b0;
    resend    = 1'b0;
    get_resp  = 1'b0;
    keep      = 1'b0;
    new_p3    = 8'd0;

    if (in_req_type == t0ax_pkg::REQ_COMMAND) begin
      // New command: P3 chosen by case
      case (in_apdu_case)
        t0ax_pkg::CASE_1: new_p3 = 8'd0;
        t0ax_pkg::CASE_2S: new_p3 = in_expected_length[7:0];
        t0ax_pkg::CASE_2E: begin
          if (in_expected_length <= t0ax_pkg::LE_SHORT_MAX) begin
            new_p3 = in_expected_length[7:0];
          end else begin
            append = 1'b1;
          end
        end
        t0ax_pkg::CASE_3S, t0ax_pkg::CASE_4S: new_p3 = in_command_length[7:0];
        t0ax_pkg::CASE_3E, t0ax_pkg::CASE_4E: begin
          if (in_command_length[15:8] == 8'd0) begin
            new_p3 = in_command_length[7:0];
          end else begin
            reject = 1'b1;
          end
        end
        default: reject = 1'b1;
      endcase

      cla_nxt   = in_cmd_class;
      ins_nxt   = in_cmd_instruction;
      p1_nxt    = in_cmd_param1;
      p2_nxt    = in_cmd_param2;
      p3_nxt    = new_p3;
      le_nxt    = in_expected_length;
      count_nxt = 8'd0;
      case_nxt  = reject ? t0ax_pkg::CASE_IDLE : in_apdu_case;

      if (reject) begin
        res_nxt.action = t0ax_pkg::ACT_REJECT;
      end else begin
        res_nxt.action           = t0ax_pkg::ACT_SEND;
        res_nxt.tpdu_class       = in_cmd_class;
        res_nxt.tpdu_instruction = in_cmd_instruction;
        res_nxt.tpdu_param1      = in_cmd_param1;
        res_nxt.tpdu_param2      = in_cmd_param2;
        res_nxt.tpdu_param3      = new_p3;
        res_nxt.append_long_le   = append;
        res_nxt.long_le_value    = append ? in_expected_length[15:0] : 16'd0;
      end
    end else begin
      // Status word: saturating exchange count
      if (count_r != t0ax_pkg::COUNT_MAX) begin
        count_nxt = count_r + 8'd1;
      end

      case (case_r)
        t0ax_pkg::CASE_2S: begin
          resend = (sw1 == t0ax_pkg::SW1_WRONG_LE);
          keep   = sw1 inside {[t0ax_pkg::SW1_NORMAL:t0ax_pkg::SW1_NORMAL_LAST]};
        end
        t0ax_pkg::CASE_2E: begin
          resend = (sw1 == t0ax_pkg::SW1_WRONG_LE);
          if (le_r <= t0ax_pkg::LE_SHORT_MAX) begin
            keep = sw1 inside {[t0ax_pkg::SW1_NORMAL:t0ax_pkg::SW1_NORMAL_LAST]};
          end
        end
        t0ax_pkg::CASE_4S: begin
          if (count_nxt >= t0ax_pkg::COUNT_SECOND) begin
            resend = (sw1 == t0ax_pkg::SW1_WRONG_LE);
            keep   = sw1 inside {[t0ax_pkg::SW1_NORMAL:t0ax_pkg::SW1_NORMAL_LAST]};
          end else if (sw1 == t0ax_pkg::SW1_NORMAL) begin
            get_resp = 1'b1;
            new_p3   = le_r[7:0];
          end else if (sw1 == t0ax_pkg::SW1_BYTES_AVAIL
                       || sw1 == t0ax_pkg::SW1_SIM_AVAIL) begin
            get_resp = 1'b1;
            new_p3   = p3_min;
          end
        end
        default: ;
      endcase

      if (resend) begin
        p3_nxt = sw2;
      end else if (get_resp) begin
        ins_nxt = t0ax_pkg::INS_GET_RESPONSE;
        p1_nxt  = 8'd0;
        p2_nxt  = 8'd0;
        p3_nxt  = new_p3;
      end

      if (resend || get_resp) begin
        res_nxt.action           = t0ax_pkg::ACT_SEND;
        res_nxt.tpdu_class       = cla_nxt;
        res_nxt.tpdu_instruction = ins_nxt;
        res_nxt.tpdu_param1      = p1_nxt;
        res_nxt.tpdu_param2      = p2_nxt;
        res_nxt.tpdu_param3      = p3_nxt;
      end else begin
        res_nxt.action       = t0ax_pkg::ACT_DONE;
        res_nxt.keep_data    = keep;
        res_nxt.final_status = in_status_word;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      case_r  <= t0ax_pkg::CASE_1;
      le_r    <= '0;
      cla_r   <= '0;
      ins_r   <= '0;
      p1_r    <= '0;
      p2_r    <= '0;
      p3_r    <= '0;
      count_r <= '0;
    end else if (accept) begin
      case_r  <= case_nxt;
      le_r    <= le_nxt;
      cla_r   <= cla_nxt;
      ins_r   <= ins_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      p3_r    <= p3_nxt;
      count_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_action           = res_r.action;
  assign out_tpdu_class       = res_r.tpdu_class;
  assign out_tpdu_instruction = res_r.tpdu_instruction;
  assign out_tpdu_param1      = res_r.tpdu_param1;
  assign out_tpdu_param2      = res_r.tpdu_param2;
  assign out_tpdu_param3      = res_r.tpdu_param3;
  assign out_append_long_le   = res_r.append_long_le;
  assign out_long_le_value    = res_r.long_le_value;
  assign out_keep_data        = res_r.keep_data;
  assign out_final_status     = res_r.final_status;

`ifndef SYNTHESIS
  // Every accepted request leaves a result in the output register
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // Oversized extended Lc is rejected
  a_long_lc_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == t0ax_pkg::REQ_COMMAND
      && (in_apdu_case == t0ax_pkg::CASE_3E || in_apdu_case == t0ax_pkg::CASE_4E)
      && in_command_length[15:8] != 8'd0
    |=> out_action == t0ax_pkg::ACT_REJECT && case_r == t0ax_pkg::CASE_IDLE)
    else $error("oversized Lc not rejected");

  // Long Le is only appended to a header send
  a_append_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_append_long_le |-> out_action == t0ax_pkg::ACT_SEND
      && out_tpdu_param3 == 8'd0)
    else $error("long Le appended outside a header send");

  // A status word never gives a reject
  a_status_no_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == t0ax_pkg::REQ_STATUS
    |=> out_action != t0ax_pkg::ACT_REJECT && !out_append_long_le)
    else $error("status word produced reject or long Le");
`endif

endmodule

### verif/tb_t0_apdu_exchange_control_core.sv
// Self-checking testbench for t0_apdu_exchange_control_core: command and status requests
// are predicted in the bench and every result is checked field by field.
// Depends on t0ax_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_t0_apdu_exchange_control_core;

  // Status bytes used by the stimulus only
  localparam logic [7:0] SW1_PROC_BASE = 8'h60;
  localparam logic [7:0] SW1_WARN      = 8'h62;
  localparam logic [7:0] SW1_FILE_ERR  = 8'h6A;
  localparam logic [7:0] SW1_VENDOR_9X = 8'h98;

  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 4;

  // One request as offered on the input channel
  typedef struct packed {
    logic        req_type;
    logic [7:0]  cla;
    logic [7:0]  ins;
    logic [7:0]  p1;
    logic [7:0]  p2;
    logic [2:0]  apdu_case;
    logic [15:0] lc;
    logic [16:0] le;
    logic [15:0] sw;
  } apdu_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [7:0]  in_cmd_class = '0;
  logic [7:0]  in_cmd_instruction = '0;
  logic [7:0]  in_cmd_param1 = '0;
  logic [7:0]  in_cmd_param2 = '0;
  logic [2:0]  in_apdu_case = '0;
  logic [15:0] in_command_length = '0;
  logic [16:0] in_expected_length = '0;
  logic [15:0] in_status_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [7:0]  out_tpdu_class;
  logic [7:0]  out_tpdu_instruction;
  logic [7:0]  out_tpdu_param1;
  logic [7:0]  out_tpdu_param2;
  logic [7:0]  out_tpdu_param3;
  logic        out_append_long_le;
  logic [15:0] out_long_le_value;
  logic        out_keep_data;
  logic [15:0] out_final_status;

  t0_apdu_exchange_control_core dut (.*);

  // Predicted exchange state
  logic [2:0]  sess_case = t0ax_pkg::CASE_1;
  logic [16:0] sess_le = '0;
  logic [7:0]  hdr_cla = '0;
  logic [7:0]  hdr_ins = '0;
  logic [7:0]  hdr_p1 = '0;
  logic [7:0]  hdr_p2 = '0;
  logic [7:0]  hdr_p3 = '0;
  logic [7:0]  sw_seen = '0;

  t0ax_pkg::result_t awaited_results[$];
  int      errors = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  int      hold_reqs = 0;
  int      hold_acks = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic t0ax_pkg::result_t header_result(input logic append,
                                                      input logic [16:0] le);
    t0ax_pkg::result_t res;
    res = '0;
    res.action = t0ax_pkg::ACT_SEND;
    res.tpdu_class = hdr_cla;
    res.tpdu_instruction = hdr_ins;
    res.tpdu_param1 = hdr_p1;
    res.tpdu_param2 = hdr_p2;
    res.tpdu_param3 = hdr_p3;
    res.append_long_le = append;
    res.long_le_value = append ? le[15:0] : 16'd0;
    return res;
  endfunction

  function automatic t0ax_pkg::result_t done_result(input logic keep,
                                                    input logic [15:0] sw);
    t0ax_pkg::result_t res;
    res = '0;
    res.action = t0ax_pkg::ACT_DONE;
    res.keep_data = keep;
    res.final_status = sw;
    return res;
  endfunction

  // GET RESPONSE reuses the stored CLA
  function automatic t0ax_pkg::result_t get_response_header(input logic [7:0] p3);
    hdr_ins = t0ax_pkg::INS_GET_RESPONSE;
    hdr_p1 = '0;
    hdr_p2 = '0;
    hdr_p3 = p3;
    return header_result(1'b0, '0);
  endfunction

  // Short-Le status handling: wrong length re-sends, 90..9F keeps the data
  function automatic t0ax_pkg::result_t short_le_decision(input logic [15:0] sw);
    if (sw[15:8] == t0ax_pkg::SW1_WRONG_LE) begin
      hdr_p3 = sw[7:0];
      return header_result(1'b0, '0);
    end
    return done_result(sw[15:8] >= t0ax_pkg::SW1_NORMAL
                       && sw[15:8] <= t0ax_pkg::SW1_NORMAL_LAST, sw);
  endfunction

  function automatic t0ax_pkg::result_t exchange_outcome(input apdu_req_t r);
    logic    append;
    logic    reject;
    logic [7:0] sw1;
    logic [7:0] sw2;
    append = 1'b0;
    reject = 1'b0;
    sw1 = r.sw[15:8];
    sw2 = r.sw[7:0];
    if (r.req_type == t0ax_pkg::REQ_COMMAND) begin
      hdr_cla = r.cla;
      hdr_ins = r.ins;
      hdr_p1 = r.p1;
      hdr_p2 = r.p2;
      sess_case = r.apdu_case;
      sess_le = r.le;
      sw_seen = '0;
      case (r.apdu_case)
        t0ax_pkg::CASE_1: hdr_p3 = '0;
        t0ax_pkg::CASE_2S: hdr_p3 = r.le[7:0];
        t0ax_pkg::CASE_2E: begin
          if (r.le <= t0ax_pkg::LE_SHORT_MAX) begin
            hdr_p3 = r.le[7:0];
          end else begin
            hdr_p3 = '0;
            append = 1'b1;
          end
        end
        t0ax_pkg::CASE_3S, t0ax_pkg::CASE_4S: hdr_p3 = r.lc[7:0];
        t0ax_pkg::CASE_3E, t0ax_pkg::CASE_4E: begin
          if ({1'b0, r.lc} < t0ax_pkg::LE_SHORT_MAX) hdr_p3 = r.lc[7:0];
          else reject = 1'b1;
        end
        default: reject = 1'b1;
      endcase
      if (reject) begin
        sess_case = t0ax_pkg::CASE_IDLE;
        hdr_p3 = '0;
        return '{action: t0ax_pkg::ACT_REJECT, default: '0};
      end
      return header_result(append, r.le);
    end

    // Status word from the card
    if (sw_seen != t0ax_pkg::COUNT_MAX) sw_seen = sw_seen + 8'd1;
    case (sess_case)
      t0ax_pkg::CASE_2S: return short_le_decision(r.sw);
      t0ax_pkg::CASE_2E: begin
        if (sess_le <= t0ax_pkg::LE_SHORT_MAX) return short_le_decision(r.sw);
        if (sw1 == t0ax_pkg::SW1_WRONG_LE) begin
          hdr_p3 = sw2;
          return header_result(1'b0, '0);
        end
        return done_result(1'b0, r.sw);
      end
      t0ax_pkg::CASE_4S: begin
        if (sw_seen >= t0ax_pkg::COUNT_SECOND) return short_le_decision(r.sw);
        if (sw1 == t0ax_pkg::SW1_NORMAL) return get_response_header(sess_le[7:0]);
        if (sw1 == t0ax_pkg::SW1_BYTES_AVAIL || sw1 == t0ax_pkg::SW1_SIM_AVAIL)
          return get_response_header((sess_le < {9'd0, sw2}) ? sess_le[7:0] : sw2);
        return done_result(1'b0, r.sw);
      end
      default: return done_result(1'b0, r.sw);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request construction
  // ---------------------------------------------------------------------------

  function automatic apdu_req_t random_request();
    apdu_req_t r;
    r.req_type = 1'($urandom_range(1));
    r.cla = 8'($urandom);
    r.ins = 8'($urandom);
    r.p1 = 8'($urandom);
    r.p2 = 8'($urandom);
    r.apdu_case = 3'($urandom);
    r.lc = 16'($urandom);
    r.le = 17'($urandom_range(65536));
    r.sw = 16'($urandom);
    return r;
  endfunction

  function automatic apdu_req_t cmd_req(input logic [2:0] c, input logic [7:0] cla,
                                        input logic [7:0] ins, input logic [7:0] p1,
                                        input logic [7:0] p2, input logic [15:0] lc,
                                        input logic [16:0] le);
    apdu_req_t r;
    r = random_request();
    r.req_type = t0ax_pkg::REQ_COMMAND;
    r.apdu_case = c;
    r.cla = cla;
    r.ins = ins;
    r.p1 = p1;
    r.p2 = p2;
    r.lc = lc;
    r.le = le;
    return r;
  endfunction

  function automatic apdu_req_t sw_req(input logic [15:0] sw);
    apdu_req_t r;
    r = random_request();
    r.req_type = t0ax_pkg::REQ_STATUS;
    r.sw = sw;
    return r;
  endfunction

  // Lengths lean towards the short/extended boundaries
  function automatic apdu_req_t random_command();
    apdu_req_t r;
    r = random_request();
    r.req_type = t0ax_pkg::REQ_COMMAND;
    r.apdu_case = ($urandom_range(99) < 4) ? t0ax_pkg::CASE_IDLE
                                           : 3'($urandom_range(6));
    case ($urandom_range(5))
      0: r.lc = '0;
      1: r.lc = 16'($urandom_range(1, 254));
      2: r.lc = 16'd255;
      3: r.lc = 16'd256;
      4: r.lc = 16'hFFFF;
      default: ;
    endcase
    case ($urandom_range(7))
      0: r.le = '0;
      1: r.le = 17'($urandom_range(1, 255));
      2: r.le = t0ax_pkg::LE_SHORT_MAX;
      3: r.le = t0ax_pkg::LE_SHORT_MAX + 17'd1;
      4: r.le = 17'd65535;
      5: r.le = 17'd65536;
      default: ;
    endcase
    return r;
  endfunction

  function automatic apdu_req_t random_status();
    apdu_req_t r;
    r = random_request();
    r.req_type = t0ax_pkg::REQ_STATUS;
    case ($urandom_range(7))
      0: r.sw[15:8] = t0ax_pkg::SW1_WRONG_LE;
      1: r.sw[15:8] = t0ax_pkg::SW1_BYTES_AVAIL;
      2: r.sw[15:8] = t0ax_pkg::SW1_SIM_AVAIL;
      3: r.sw[15:8] = t0ax_pkg::SW1_NORMAL;
      4: r.sw[15:8] = SW1_PROC_BASE | 8'($urandom_range(15));
      5: r.sw[15:8] = t0ax_pkg::SW1_NORMAL | 8'($urandom_range(15));
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and result checker
  // ---------------------------------------------------------------------------

  task automatic send_request(input apdu_req_t r);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_cmd_class <= r.cla;
    in_cmd_instruction <= r.ins;
    in_cmd_param1 <= r.p1;
    in_cmd_param2 <= r.p2;
    in_apdu_case <= r.apdu_case;
    in_command_length <= r.lc;
    in_expected_length <= r.le;
    in_status_word <= r.sw;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(exchange_outcome(r));
  endtask

  // Sender goes quiet until every outstanding result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    t0ax_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with none outstanding: action %0d", out_action);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        check_field("action", 16'(want.action), 16'(out_action));
        check_field("tpdu_class", 16'(want.tpdu_class), 16'(out_tpdu_class));
        check_field("tpdu_instruction", 16'(want.tpdu_instruction),
                    16'(out_tpdu_instruction));
        check_field("tpdu_param1", 16'(want.tpdu_param1), 16'(out_tpdu_param1));
        check_field("tpdu_param2", 16'(want.tpdu_param2), 16'(out_tpdu_param2));
        check_field("tpdu_param3", 16'(want.tpdu_param3), 16'(out_tpdu_param3));
        check_field("append_long_le", 16'(want.append_long_le),
                    16'(out_append_long_le));
        check_field("long_le_value", want.long_le_value, out_long_le_value);
        check_field("keep_data", 16'(want.keep_data), 16'(out_keep_data));
        check_field("final_status", want.final_status, out_final_status);
      end
    end
  end

  // Receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_reqs != hold_acks) begin
      hold_acks <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("t0_apdu_exchange_control_core test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every case, every action and the corner cases of the mapping
  task automatic test_directed();
    // status before any command finishes
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // case 1 with all-ones header and lengths
    send_request(cmd_req(t0ax_pkg::CASE_1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF,
                         17'd65536));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // 2S, Le of 256 gives P3 0; wrong length re-send then normal end keeps data
    send_request(cmd_req(t0ax_pkg::CASE_2S, 8'h00, 8'hB0, 8'h00, 8'h00, 16'd0,
                         t0ax_pkg::LE_SHORT_MAX));
    send_request(sw_req({t0ax_pkg::SW1_WRONG_LE, 8'h37}));
    send_request(sw_req({SW1_VENDOR_9X, 8'h04}));
    // 2E long Le: appended, then re-sent short, then 9000 drops the data
    send_request(cmd_req(t0ax_pkg::CASE_2E, 8'h80, 8'hCA, 8'h01, 8'h02, 16'd0,
                         17'd65536));
    send_request(sw_req({t0ax_pkg::SW1_WRONG_LE, 8'h10}));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // 2E at the short boundary behaves as 2S
    send_request(cmd_req(t0ax_pkg::CASE_2E, 8'h00, 8'hB2, 8'h00, 8'h00, 16'd0,
                         t0ax_pkg::LE_SHORT_MAX));
    send_request(sw_req({t0ax_pkg::SW1_SIM_AVAIL, 8'h00}));
    // 3S takes the low byte of Lc
    send_request(cmd_req(t0ax_pkg::CASE_3S, 8'h00, 8'hD6, 8'h00, 8'h00, 16'h01FF,
                         17'd0));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // 3E just short enough, then 4E oversized rejected
    send_request(cmd_req(t0ax_pkg::CASE_3E, 8'h00, 8'hD6, 8'h00, 8'h00, 16'd255,
                         17'd0));
    send_request(cmd_req(t0ax_pkg::CASE_4E, 8'h00, 8'hE2, 8'h00, 8'h00, 16'd256,
                         17'd300));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // unused case code
    send_request(cmd_req(t0ax_pkg::CASE_IDLE, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0,
                         17'd0));
    // 4S: bytes available, then handled as 2S
    send_request(cmd_req(t0ax_pkg::CASE_4S, 8'hA0, 8'h88, 8'h00, 8'h00, 16'd5,
                         17'h20));
    send_request(sw_req({t0ax_pkg::SW1_BYTES_AVAIL, 8'h10}));
    send_request(sw_req({t0ax_pkg::SW1_WRONG_LE, 8'h08}));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    // 4S: 9000 first asks GET RESPONSE with P3 from Le
    send_request(cmd_req(t0ax_pkg::CASE_4S, 8'h00, 8'hA4, 8'h04, 8'h00, 16'd2,
                         17'h1FF));
    send_request(sw_req({t0ax_pkg::SW1_NORMAL, 8'h00}));
    send_request(sw_req({SW1_WARN, 8'h82}));
    // 4S: file error on the first status finishes
    send_request(cmd_req(t0ax_pkg::CASE_4S, 8'h00, 8'hA4, 8'h04, 8'h00, 16'd2,
                         17'd0));
    send_request(sw_req({SW1_FILE_ERR, 8'h82}));
  endtask

  // Mostly well-formed exchanges with random content, some noise
  task automatic test_random_exchanges(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 85) begin
        send_request(random_command());
        sent++;
        repeat ($urandom_range(1, 4)) begin
          send_request(random_status());
          sent++;
        end
      end else begin
        send_request(random_request());
        sent++;
      end
    end
  endtask

  // Long receiver hold-off fills the block; then the sender waits for the backlog
  task automatic test_backpressure();
    hold_reqs <= hold_reqs + 1;
    test_random_exchanges(40);
    wait_drained();
    test_random_exchanges(20);
  endtask

  // Long status run after a 4S command drives the status counter to saturation
  task automatic test_status_saturation();
    send_request(cmd_req(t0ax_pkg::CASE_4S, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 16'd16, 17'd64));
    repeat (260) send_request(random_status());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 6;
    rx_idle_pct = 80;
    test_directed();
    test_random_exchanges(330);

    tx_idle_pct = 80;
    rx_idle_pct = 6;
    test_random_exchanges(330);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_status_saturation();
    test_random_exchanges(330);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("t0_apdu_exchange_control_core test passed");
    end else begin
      $display("t0_apdu_exchange_control_core test failed");
    end
    $finish;
  end

endmodule

### files.f
design/t0ax_pkg.sv
design/t0_apdu_exchange_control_core.sv
verif/tb_t0_apdu_exchange_control_core.sv
